@@ rtl/core/tfo_pkg.sv @@
// Shared constants and types for the tangent frame orthonormaliser.
// Used by tfo_unit_scale, tangent_frame_orthonormalize and tfo_checker.
package tfo_pkg;

  localparam int MAG_BITS      = 31;
  localparam int SUM_BITS      = 64;
  localparam int CFG_DATA_BITS = 16;
  localparam int DEG_BITS      = 16;
  localparam int AXIS_BITS     = 15;

  localparam logic [DEG_BITS-1:0]  DEG_LIMIT_RESET  = 16'd3;
  localparam logic [AXIS_BITS-1:0] AXIS_LIMIT_RESET = 15'd16368;

  localparam logic REG_DEGENERATE_LIMIT  = 1'b0;
  localparam logic REG_AXIS_SWITCH_LIMIT = 1'b1;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK          = 2'd0;
  localparam status_t ST_FALLBACK    = 2'd1;
  localparam status_t ST_ZERO_NORMAL = 2'd2;

  typedef logic [MAG_BITS-1:0] mag_t;

endpackage

@@ rtl/core/tfo_unit_scale.sv @@
// Pipelined unit-length scaling of a signed three-component vector.
// Square sum, normalising shift, bit-per-stage square root and divider.
// Depends on tfo_pkg.
module tfo_unit_scale
  import tfo_pkg::*;
#(
  parameter int IW = 16,
  parameter int FB = 14,
  parameter int SW = 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [3*IW-1:0]       in_vec,
  input  logic [SW-1:0]         in_side,
  output logic                  out_valid,
  output logic [3*(FB+2)-1:0]   out_vec,
  output logic                  out_nz,
  output logic [SW-1:0]         out_side
);

  localparam int OW   = FB + 2;
  localparam int HMAX = (IW > MAG_BITS) ? IW - MAG_BITS : 0;
  localparam int HW   = $clog2(HMAX + 2);
  localparam int NSQ  = 32;
  localparam int KW   = 5;
  localparam int CW   = 3*MAG_BITS + 3 + KW + 1;
  localparam int LAT  = NSQ + FB + 7;

  logic [LAT-1:0] vld;
  logic [SW-1:0]  side_q [LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_q[0] <= in_side;
      for (int j = 1; j < LAT; j++) side_q[j] <= side_q[j-1];
    end
  end

  assign out_valid = vld[LAT-1];
  assign out_side  = side_q[LAT-1];

  logic [IW-1:0] mag_c [3];
  logic [IW-1:0] or_c;
  logic [HW-1:0] h_c;

  always_comb begin
    or_c = '0;
    for (int i = 0; i < 3; i++) begin
      mag_c[i] = in_vec[i*IW+IW-1] ? ~in_vec[i*IW +: IW] + 1'b1 : in_vec[i*IW +: IW];
      or_c = or_c | mag_c[i];
    end
    h_c = HW'(HMAX);
    for (int h = HMAX; h >= 0; h--) begin
      if (64'(or_c >> h) < (64'd1 << MAG_BITS)) h_c = HW'(h);
    end
  end

  mag_t          m1 [3], m2 [3], m3 [3], m4 [3];
  logic [2:0]    sg1, sg2, sg3, sg4;
  logic [61:0]   sq2 [3];
  logic [63:0]   s3, x4;
  logic [KW-1:0] k4;
  logic          nz4;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        m1[i]  <= MAG_BITS'(mag_c[i] >> h_c);
        sg1[i] <= in_vec[i*IW+IW-1];
        sq2[i] <= 62'(m1[i]) * 62'(m1[i]);
      end
      m2  <= m1;
      sg2 <= sg1;
      s3  <= 64'(sq2[0]) + 64'(sq2[1]) + 64'(sq2[2]);
      m3  <= m2;
      sg3 <= sg2;
    end
  end

  logic [63:0]   x4_c, x5_c;
  logic [KW-1:0] k4_c, k5_c;

  always_comb begin
    x4_c = s3;
    k4_c = '0;
    if (x4_c < (64'd1 << 30)) begin
      x4_c = x4_c << 32;
      k4_c = k4_c + KW'(16);
    end
    if (x4_c < (64'd1 << 46)) begin
      x4_c = x4_c << 16;
      k4_c = k4_c + KW'(8);
    end
  end

  always_comb begin
    x5_c = x4;
    k5_c = k4;
    if (x5_c < (64'd1 << 54)) begin
      x5_c = x5_c << 8;
      k5_c = k5_c + KW'(4);
    end
    if (x5_c < (64'd1 << 58)) begin
      x5_c = x5_c << 4;
      k5_c = k5_c + KW'(2);
    end
    if (x5_c < (64'd1 << 60)) begin
      x5_c = x5_c << 2;
      k5_c = k5_c + KW'(1);
    end
  end

  logic [63:0]   sx [NSQ];
  logic [63:0]   sr [NSQ+1];
  logic [CW-1:0] sc [NSQ+1];

  always_ff @(posedge clk) begin
    if (en) begin
      x4    <= x4_c;
      k4    <= k4_c;
      nz4   <= (s3 != '0);
      m4    <= m3;
      sg4   <= sg3;
      sx[0] <= x5_c;
      sr[0] <= '0;
      sc[0] <= {m4[2], m4[1], m4[0], sg4, k5_c, nz4};
    end
  end

  for (genvar j = 0; j < NSQ; j++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (62 - 2*j);
    logic [63:0] t;
    logic        ge;
    assign t  = sr[j] + BIT;
    assign ge = sx[j] >= t;

    always_ff @(posedge clk) begin
      if (en) begin
        sr[j+1] <= ge ? (sr[j] >> 1) + BIT : sr[j] >> 1;
        sc[j+1] <= sc[j];
      end
    end

    if (j < NSQ - 1) begin : g_x
      always_ff @(posedge clk) begin
        if (en) sx[j+1] <= ge ? sx[j] - t : sx[j];
      end
    end
  end

  logic [31:0] root_c;
  logic [31:0] num_c [3];
  logic [KW-1:0] k_c;

  assign root_c = sr[NSQ][31:0];
  assign k_c    = sc[NSQ][KW:1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num_c[i] = 32'(64'(sc[NSQ][KW+4+i*MAG_BITS +: MAG_BITS]) << k_c);
    end
  end

  logic [31:0] dR [FB+1][3];
  logic [FB:0] dQ [FB+1][3];
  logic [31:0] dv [FB+1];
  logic [3:0]  dc [FB+1];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dR[0][i] <= (num_c[i] >= root_c) ? num_c[i] - root_c : num_c[i];
        dQ[0][i] <= (FB+1)'(num_c[i] >= root_c);
      end
      dv[0] <= root_c;
      dc[0] <= {sc[NSQ][KW+3:KW+1], sc[NSQ][0]};
    end
  end

  for (genvar j = 0; j < FB; j++) begin : g_div
    logic [32:0] rem2 [3];
    logic [2:0]  qb;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        rem2[i] = {dR[j][i], 1'b0};
        qb[i]   = rem2[i] >= {1'b0, dv[j]};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          dR[j+1][i] <= qb[i] ? 32'(rem2[i] - {1'b0, dv[j]}) : rem2[i][31:0];
          dQ[j+1][i] <= {dQ[j][i][FB-1:0], qb[i]};
        end
        dv[j+1] <= dv[j];
        dc[j+1] <= dc[j];
      end
    end
  end

  logic [OW-1:0] q_c [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q_c[i] = OW'(dQ[FB][i])
             + OW'((33'(dR[FB][i]) + 33'(dv[FB] >> 1)) >= 33'(dv[FB]));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (!dc[FB][0]) begin
          out_vec[i*OW +: OW] <= '0;
        end else begin
          out_vec[i*OW +: OW] <= dc[FB][i+1] ? ~q_c[i] + 1'b1 : q_c[i];
        end
      end
      out_nz <= dc[FB][0];
    end
  end

endmodule

@@ rtl/core/tangent_frame_orthonormalize.sv @@
// Top level of the tangent frame orthonormaliser.
// Depends on tfo_pkg and tfo_unit_scale.
//
// Input stream s_*: one vertex per transfer, normal and tangent in signed
// fixed point with COMPONENT_BITS bits, two of them integer bits.
// Output stream m_*: unit normal and orthonormal unit tangent, with the
// frame status on m_tuser (ok, fallback axis used, zero normal).
// A zero normal gives all-zero vectors; a degenerate tangent residual is
// replaced by the cross product of the Y axis (or X when |normal Y| reaches
// axis_switch_limit) with the unit normal.
// Configuration: cfg_we writes cfg_data to register cfg_index
// (0 degenerate_limit, 1 axis_switch_limit) at a clock edge; write only
// while the pipeline is empty.
// Throughput: one vertex per cycle while the receiver does not stall. The two
// unit-scale pipelines each hold a 32-stage square root and a
// one-bit-per-stage divider.
// Reset (rst, synchronous) empties the pipeline and restores the register
// defaults. When the receiver stalls, the whole pipeline holds and s_tready
// drops until the waiting result is taken.
module tangent_frame_orthonormalize
  import tfo_pkg::*;
#(
  parameter int COMPONENT_BITS = 16,
  localparam int DATA_BITS = ((6*COMPONENT_BITS + 7) / 8) * 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  // normal_x, normal_y, normal_z, tangent_x, tangent_y, tangent_z
  input  logic [DATA_BITS-1:0]     s_tdata,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  // unit_normal_x/y/z, unit_tangent_x/y/z
  output logic [DATA_BITS-1:0]     m_tdata,
  // frame_status
  output status_t                  m_tuser
);

  localparam int W   = COMPONENT_BITS;
  localparam int F   = W - 2;
  localparam int DRW = W + 2;
  localparam int RW  = W + 3;
  localparam int F2  = 2 * F;
  localparam int SW2 = 3*W + 3;

  logic [DEG_BITS-1:0]  deg_limit;
  logic [AXIS_BITS-1:0] axis_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      deg_limit  <= DEG_LIMIT_RESET;
      axis_limit <= AXIS_LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEGENERATE_LIMIT:  deg_limit  <= cfg_data[DEG_BITS-1:0];
        REG_AXIS_SWITCH_LIMIT: axis_limit <= cfg_data[AXIS_BITS-1:0];
        default: ;
      endcase
    end
  end

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  logic          u1_valid, u1_nz;
  logic [3*W-1:0] u1_vec, u1_side;

  tfo_unit_scale #(.IW(W), .FB(F), .SW(3*W)) u_norm (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s_tvalid),
    .in_vec   (s_tdata[3*W-1:0]),
    .in_side  (s_tdata[6*W-1:3*W]),
    .out_valid(u1_valid),
    .out_vec  (u1_vec),
    .out_nz   (u1_nz),
    .out_side (u1_side)
  );

  logic signed [W-1:0] un0 [3], tv0 [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      un0[i] = u1_vec[i*W +: W];
      tv0[i] = u1_side[i*W +: W];
    end
  end

  logic [8:1] v;
  logic [8:1] nz;
  logic signed [W-1:0]   un1 [3], un2 [3], un3 [3], un4 [3], un5 [3], un6 [3], un7 [3];
  logic signed [W-1:0]   un8 [3];
  logic signed [W-1:0]   tv1 [3], tv2 [3], tv3 [3], tv4 [3];
  logic signed [2*W-1:0] p1 [3];
  logic signed [2*W+1:0] dot2;
  logic signed [DRW-1:0] dr3;
  logic signed [2*W+1:0] pr4 [3];
  logic signed [RW-1:0]  res5 [3], res6 [3], res7 [3], res8 [3];
  logic [61:0]           sq6 [3];
  logic                  big6, fbx6, fbx7, deg7;
  status_t               st8;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[7:1], u1_valid};
    end
  end

  logic [2*W+1:0] dmag_c, dround_c;
  always_comb begin
    dmag_c   = dot2[2*W+1] ? ~dot2 + 1'b1 : dot2;
    dround_c = (dmag_c + ((2*W+2)'(1) << (F-1))) >> F;
  end

  logic [2*W+1:0]        pmag_c [3], pround_c [3];
  logic signed [DRW-1:0] prnd_c [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pmag_c[i]   = pr4[i][2*W+1] ? ~pr4[i] + 1'b1 : pr4[i];
      pround_c[i] = (pmag_c[i] + ((2*W+2)'(1) << (F-1))) >> F;
      prnd_c[i]   = pr4[i][2*W+1] ? ~DRW'(pround_c[i]) + 1'b1 : DRW'(pround_c[i]);
    end
  end

  logic [RW-1:0]    rmag_c [3];
  logic [RW-1:0]    ror_c;
  mag_t             rsm_c [3];
  logic [W-1:0]     uy_mag_c;
  always_comb begin
    ror_c = '0;
    for (int i = 0; i < 3; i++) begin
      rmag_c[i] = res5[i][RW-1] ? ~res5[i] + 1'b1 : res5[i];
      rsm_c[i]  = MAG_BITS'(rmag_c[i]);
      ror_c     = ror_c | rmag_c[i];
    end
    uy_mag_c = un5[1][W-1] ? ~un5[1] + 1'b1 : un5[1];
  end

  logic [SUM_BITS-1:0] sum7_c;
  logic                below7_c;
  assign sum7_c = SUM_BITS'(sq6[0]) + SUM_BITS'(sq6[1]) + SUM_BITS'(sq6[2]);

  if (F2 >= 28) begin : g_deg_up
    assign below7_c = sum7_c < (SUM_BITS'(deg_limit) << (F2 - 28));
  end else begin : g_deg_dn
    assign below7_c = (sum7_c < SUM_BITS'(65536))
                   && ((sum7_c << (28 - F2)) < SUM_BITS'(deg_limit));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nz <= {nz[7:1], u1_nz};
      for (int i = 0; i < 3; i++) begin
        un1[i]  <= un0[i];
        tv1[i]  <= tv0[i];
        p1[i]   <= un0[i] * tv0[i];
        pr4[i]  <= un3[i] * dr3;
        res5[i] <= tv4[i] - prnd_c[i];
        sq6[i]  <= 62'(rsm_c[i]) * 62'(rsm_c[i]);
      end
      un2  <= un1;
      tv2  <= tv1;
      dot2 <= p1[0] + p1[1] + p1[2];
      un3  <= un2;
      tv3  <= tv2;
      dr3  <= dot2[2*W+1] ? ~DRW'(dround_c) + 1'b1 : DRW'(dround_c);
      un4  <= un3;
      tv4  <= tv3;
      un5  <= un4;
      un6  <= un5;
      res6 <= res5;
      big6 <= SUM_BITS'(ror_c) >= (SUM_BITS'(1) << MAG_BITS);
      fbx6 <= !((SUM_BITS'(uy_mag_c) << 14) < (SUM_BITS'(axis_limit) << F));
      un7  <= un6;
      res7 <= res6;
      fbx7 <= fbx6;
      deg7 <= !big6 && below7_c;
      un8  <= un7;
      if (deg7) begin
        st8 <= ST_FALLBACK;
        if (fbx7) begin
          res8[0] <= '0;
          res8[1] <= -un7[2];
          res8[2] <= un7[1];
        end else begin
          res8[0] <= un7[2];
          res8[1] <= '0;
          res8[2] <= -un7[0];
        end
      end else begin
        st8  <= ST_OK;
        res8 <= res7;
      end
    end
  end

  logic [3*RW-1:0] u2_in;
  always_comb begin
    for (int i = 0; i < 3; i++) u2_in[i*RW +: RW] = res8[i];
  end

  logic [SW2-1:0] u2_side_in, u2_side;
  assign u2_side_in = {st8, nz[8], un8[2], un8[1], un8[0]};

  logic          u2_valid, u2_nz;
  logic [3*W-1:0] u2_vec;

  tfo_unit_scale #(.IW(RW), .FB(F), .SW(SW2)) u_tan (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v[8]),
    .in_vec   (u2_in),
    .in_side  (u2_side_in),
    .out_valid(u2_valid),
    .out_vec  (u2_vec),
    .out_nz   (u2_nz),
    .out_side (u2_side)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= u2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (!u2_side[3*W]) begin
        m_tdata <= '0;
        m_tuser <= ST_ZERO_NORMAL;
      end else begin
        m_tdata <= DATA_BITS'({u2_nz ? u2_vec : {3*W{1'b0}}, u2_side[3*W-1:0]});
        m_tuser <= u2_side[SW2-1 -: 2];
      end
    end
  end

endmodule

@@ rtl/core/tfo_checker.sv @@
// Port-level checks on the tangent frame orthonormaliser, bound to the top.
// Depends on tfo_pkg and tangent_frame_orthonormalize.
module tfo_checker
  import tfo_pkg::*;
#(
  parameter int COMPONENT_BITS = 16,
  localparam int DATA_BITS = ((6*COMPONENT_BITS + 7) / 8) * 8
) (
  input logic                     clk,
  input logic                     rst,
  input logic                     cfg_we,
  input logic                     cfg_index,
  input logic [CFG_DATA_BITS-1:0] cfg_data,
  input logic                     s_tvalid,
  input logic                     s_tready,
  input logic [DATA_BITS-1:0]     s_tdata,
  input logic                     m_tvalid,
  input logic                     m_tready,
  input logic [DATA_BITS-1:0]     m_tdata,
  input status_t                  m_tuser
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled transfer changed");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not follow output stall");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ST_ZERO_NORMAL |-> m_tdata == '0)
    else $error("zero normal with non-zero vectors");

endmodule

bind tangent_frame_orthonormalize tfo_checker #(.COMPONENT_BITS(COMPONENT_BITS)) u_tfo_checker (.*);
